// ===== hw/rtl/block_buffer_cache_lru_defines.svh =====
// Assertion macros for the block buffer cache checker.
`ifndef BLOCK_BUFFER_CACHE_LRU_DEFINES_SVH
`define BLOCK_BUFFER_CACHE_LRU_DEFINES_SVH

// Same-cycle implication, sampled on the block clock, off during reset.
`define BBC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("block buffer cache check failed");

// Next-cycle implication.
`define BBC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("block buffer cache check failed");

`endif

// ===== hw/rtl/bbc_pkg.sv =====
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types, codes and sizes of the block buffer cache tag engine.
// ----------------------------------------------------------------------------
package bbc_pkg;

    localparam int NUM_BUFFERS = 16;
    localparam int IDX_W       = $clog2(NUM_BUFFERS);
    localparam int SLOT_W      = 4;
    localparam int QDEPTH      = 2;

    // request codes
    localparam logic [3:0] REQ_GET       = 4'd0;
    localparam logic [3:0] REQ_PUT       = 4'd1;
    localparam logic [3:0] REQ_DIRTY     = 4'd2;
    localparam logic [3:0] REQ_FILL_DONE = 4'd3;
    localparam logic [3:0] REQ_WB_DONE   = 4'd4;
    localparam logic [3:0] REQ_FLUSH_DEV = 4'd5;
    localparam logic [3:0] REQ_FLUSH_ALL = 4'd6;
    localparam logic [3:0] REQ_INV_DEV   = 4'd7;
    localparam logic [3:0] REQ_INV_ALL   = 4'd8;

    // result status codes
    localparam logic [1:0] ST_HIT     = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_NO_FREE = 2'd2;
    localparam logic [1:0] ST_DONE    = 2'd3;

    // device command codes
    localparam logic [1:0] IO_NONE  = 2'd0;
    localparam logic [1:0] IO_READ  = 2'd1;
    localparam logic [1:0] IO_WRITE = 2'd2;

    typedef enum logic [3:0] {
        OP_GET, OP_PUT, OP_DIRTY, OP_FILL, OP_WBDONE,
        OP_FLUSH_DEV, OP_FLUSH_ALL, OP_INV_DEV, OP_INV_ALL,
        OP_BAD_SLOT, OP_UNKNOWN
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [7:0]        dev;
        logic [31:0]       blk;
        logic [SLOT_W-1:0] slot;
        logic              ok;
    } t_item;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [1:0]        status;
        logic [1:0]        io_cmd;
        logic [7:0]        dev;
        logic [31:0]       blk;
        logic              ready;
        logic              last;
    } t_result;

    function automatic t_result mk_res(logic [SLOT_W-1:0] slot, logic [1:0] status,
                                       logic [1:0] io_cmd, logic [7:0] dev,
                                       logic [31:0] blk, logic ready, logic last);
        t_result r;
        r.slot   = slot;
        r.status = status;
        r.io_cmd = io_cmd;
        r.dev    = dev;
        r.blk    = blk;
        r.ready  = ready;
        r.last   = last;
        return r;
    endfunction

endpackage

// ===== hw/rtl/bbc_front.sv =====
// ----------------------------------------------------------------------------
// bbc_front
// Accepts request items and classifies them into engine operations.
// ----------------------------------------------------------------------------
module bbc_front (
    input  logic                      start,
    input  logic [3:0]                i_req_type,
    input  logic [7:0]                i_dev_id,
    input  logic [31:0]               i_block_num,
    input  logic [3:0]                i_slot,
    input  logic                      i_io_ok,
    input  logic                      i_q_full,
    output logic                      o_busy,
    output logic                      o_push,
    output bbc_pkg::t_item            o_item
);
    import bbc_pkg::*;

    logic slot_bad;

    assign slot_bad = 32'(i_slot) >= 32'(NUM_BUFFERS);
    assign o_busy   = i_q_full;
    assign o_push   = start && !i_q_full;

    always_comb begin
        o_item.dev  = i_dev_id;
        o_item.blk  = i_block_num;
        o_item.slot = i_slot;
        o_item.ok   = i_io_ok;
        case (i_req_type)
            REQ_GET:       o_item.op = OP_GET;
            REQ_PUT:       o_item.op = slot_bad ? OP_BAD_SLOT : OP_PUT;
            REQ_DIRTY:     o_item.op = slot_bad ? OP_BAD_SLOT : OP_DIRTY;
            REQ_FILL_DONE: o_item.op = slot_bad ? OP_BAD_SLOT : OP_FILL;
            REQ_WB_DONE:   o_item.op = slot_bad ? OP_BAD_SLOT : OP_WBDONE;
            REQ_FLUSH_DEV: o_item.op = OP_FLUSH_DEV;
            REQ_FLUSH_ALL: o_item.op = OP_FLUSH_ALL;
            REQ_INV_DEV:   o_item.op = OP_INV_DEV;
            REQ_INV_ALL:   o_item.op = OP_INV_ALL;
            default:       o_item.op = OP_UNKNOWN;
        endcase
    end

endmodule

// ===== hw/rtl/bbc_queue.sv =====
// ----------------------------------------------------------------------------
// bbc_queue
// Two-entry queue of classified items between front and engine.
// ----------------------------------------------------------------------------
module bbc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bbc_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output bbc_pkg::t_item o_item
);
    import bbc_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    t_item           r_mem [QDEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [PW:0]     r_cnt;
    logic            do_pop;

    assign o_full  = r_cnt == (PW+1)'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_mem[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_item;
                r_wp        <= (r_wp == PW'(QDEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop)
                r_rp <= (r_rp == PW'(QDEPTH-1)) ? '0 : r_rp + 1'b1;
            case ({i_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== hw/rtl/bbc_engine.sv =====
// ----------------------------------------------------------------------------
// bbc_engine
// Tag store and replacement engine: lookup, victim scan, flush and invalidate.
// ----------------------------------------------------------------------------
module bbc_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  bbc_pkg::t_item   i_item,
    output logic             o_pop,
    output logic             o_valid,
    output bbc_pkg::t_result o_res
);
    import bbc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_LOOKUP, S_SCAN, S_VIC, S_FILL, S_FLUSH, S_FLUSH_END, S_INV
    } t_state;

    t_state              r_state;
    t_item               r_item;
    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    r_vic;
    logic [IDX_W-1:0]    r_vrank;
    logic                r_vfound;
    logic                r_ov;
    t_result             r_res;

    logic [7:0]          r_tdev  [NUM_BUFFERS];
    logic [31:0]         r_tblk  [NUM_BUFFERS];
    logic [7:0]          r_cnt   [NUM_BUFFERS];
    logic [IDX_W-1:0]    r_rank  [NUM_BUFFERS];
    logic [NUM_BUFFERS-1:0] r_map;
    logic [NUM_BUFFERS-1:0] r_val;
    logic [NUM_BUFFERS-1:0] r_dirty;

    logic [NUM_BUFFERS-1:0] hit_vec;
    logic [IDX_W-1:0]    hit_idx;
    logic                hit_any;
    logic [IDX_W-1:0]    rd_idx;
    logic [7:0]          e_tdev;
    logic [31:0]         e_tblk;
    logic [7:0]          e_cnt;
    logic [7:0]          e_cnt_dec;
    logic [IDX_W-1:0]    e_rank;
    logic                e_map;
    logic                e_val;
    logic                e_dirty;
    logic                idx_last;
    logic [SLOT_W-1:0]   rd_slot;

    localparam logic [IDX_W-1:0] RANK_TOP = IDX_W'(NUM_BUFFERS-1);

    always_comb begin
        hit_idx = '0;
        for (int i = NUM_BUFFERS-1; i >= 0; i--) begin
            hit_vec[i] = r_map[i] && (r_tdev[i] == r_item.dev) && (r_tblk[i] == r_item.blk);
            if (hit_vec[i])
                hit_idx = IDX_W'(i);
        end
    end
    assign hit_any = |hit_vec;

    // one read address into the slot store
    always_comb begin
        case (r_state)
            S_LOOKUP: rd_idx = (r_item.op == OP_GET) ? hit_idx : r_vic;
            S_VIC:    rd_idx = r_vic;
            S_FILL:   rd_idx = r_vic;
            default:  rd_idx = r_idx;
        endcase
    end

    assign e_tdev    = r_tdev[rd_idx];
    assign e_tblk    = r_tblk[rd_idx];
    assign e_cnt     = r_cnt[rd_idx];
    assign e_rank    = r_rank[rd_idx];
    assign e_map     = r_map[rd_idx];
    assign e_val     = r_val[rd_idx];
    assign e_dirty   = r_dirty[rd_idx];
    assign e_cnt_dec = (e_cnt != 8'd0) ? e_cnt - 8'd1 : e_cnt;
    assign idx_last  = r_idx == RANK_TOP;
    assign rd_slot   = SLOT_W'(rd_idx);

    assign o_pop   = (r_state == S_IDLE) && i_q_valid;
    assign o_valid = r_ov;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ov     <= 1'b0;
            r_idx    <= '0;
            r_vic    <= '0;
            r_vrank  <= '0;
            r_vfound <= 1'b0;
            r_map    <= '0;
            r_val    <= '0;
            r_dirty  <= '0;
            for (int i = 0; i < NUM_BUFFERS; i++) begin
                r_tdev[i] <= '0;
                r_tblk[i] <= '0;
                r_cnt[i]  <= '0;
                r_rank[i] <= IDX_W'(i);
            end
        end else begin
            r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_item   <= i_item;
                        r_vic    <= IDX_W'(i_item.slot);
                        r_idx    <= '0;
                        r_vfound <= 1'b0;
                        case (i_item.op)
                            OP_FLUSH_DEV, OP_FLUSH_ALL: r_state <= S_FLUSH;
                            OP_INV_DEV, OP_INV_ALL:     r_state <= S_INV;
                            default:                    r_state <= S_LOOKUP;
                        endcase
                    end
                end
                S_LOOKUP: begin
                    r_state <= S_IDLE;
                    r_ov    <= 1'b1;
                    case (r_item.op)
                        OP_GET: begin
                            if (hit_any) begin
                                if (e_cnt != 8'hFF)
                                    r_cnt[rd_idx] <= e_cnt + 8'd1;
                                for (int j = 0; j < NUM_BUFFERS; j++)
                                    if (r_rank[j] > e_rank)
                                        r_rank[j] <= r_rank[j] - 1'b1;
                                r_rank[rd_idx] <= RANK_TOP;
                                r_res <= mk_res(rd_slot, ST_HIT, IO_NONE, '0, '0, e_val, 1'b1);
                            end else begin
                                // miss: scan for the oldest free slot
                                r_ov    <= 1'b0;
                                r_state <= S_SCAN;
                            end
                        end
                        OP_PUT: begin
                            r_cnt[rd_idx] <= e_cnt_dec;
                            if (e_cnt_dec == 8'd0 && e_val && e_dirty)
                                r_res <= mk_res(rd_slot, ST_DONE, IO_WRITE, e_tdev, e_tblk,
                                                1'b1, 1'b1);
                            else
                                r_res <= mk_res(rd_slot, ST_DONE, IO_NONE, '0, '0, e_val, 1'b1);
                        end
                        OP_DIRTY: begin
                            r_dirty[rd_idx] <= 1'b1;
                            r_res <= mk_res(rd_slot, ST_DONE, IO_NONE, '0, '0, e_val, 1'b1);
                        end
                        OP_FILL: begin
                            if (e_map && !e_val && r_item.ok) begin
                                r_val[rd_idx] <= 1'b1;
                                r_res <= mk_res(rd_slot, ST_DONE, IO_NONE, '0, '0, 1'b1, 1'b1);
                            end else if (e_map && !e_val) begin
                                // failed fill: unmap and push to the oldest end
                                r_map[rd_idx]   <= 1'b0;
                                r_dirty[rd_idx] <= 1'b0;
                                r_cnt[rd_idx]   <= '0;
                                for (int j = 0; j < NUM_BUFFERS; j++)
                                    if (r_rank[j] < e_rank)
                                        r_rank[j] <= r_rank[j] + 1'b1;
                                r_rank[rd_idx] <= '0;
                                r_res <= mk_res(rd_slot, ST_DONE, IO_NONE, '0, '0, 1'b0, 1'b1);
                            end else begin
                                r_res <= mk_res(rd_slot, ST_DONE, IO_NONE, '0, '0, e_val, 1'b1);
                            end
                        end
                        OP_WBDONE: begin
                            if (r_item.ok)
                                r_dirty[rd_idx] <= 1'b0;
                            r_res <= mk_res(rd_slot, ST_DONE, IO_NONE, '0, '0, e_val, 1'b1);
                        end
                        OP_BAD_SLOT: begin
                            r_res <= mk_res(r_item.slot, ST_DONE, IO_NONE, '0, '0, 1'b0, 1'b1);
                        end
                        default: begin
                            r_res <= mk_res('0, ST_DONE, IO_NONE, '0, '0, 1'b0, 1'b1);
                        end
                    endcase
                end
                S_SCAN: begin
                    if (e_cnt == 8'd0 && (!r_vfound || e_rank < r_vrank)) begin
                        r_vfound <= 1'b1;
                        r_vic    <= r_idx;
                        r_vrank  <= e_rank;
                    end
                    r_idx <= r_idx + 1'b1;
                    if (idx_last)
                        r_state <= S_VIC;
                end
                S_VIC: begin
                    r_ov <= 1'b1;
                    if (!r_vfound) begin
                        r_res   <= mk_res('0, ST_NO_FREE, IO_NONE, '0, '0, 1'b0, 1'b1);
                        r_state <= S_IDLE;
                    end else if (e_val && e_dirty) begin
                        r_res   <= mk_res(rd_slot, ST_MISS, IO_WRITE, e_tdev, e_tblk,
                                          1'b0, 1'b0);
                        r_state <= S_FILL;
                    end else begin
                        r_ov    <= 1'b0;
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    r_tdev[rd_idx]  <= r_item.dev;
                    r_tblk[rd_idx]  <= r_item.blk;
                    r_map[rd_idx]   <= 1'b1;
                    r_val[rd_idx]   <= 1'b0;
                    r_dirty[rd_idx] <= 1'b0;
                    r_cnt[rd_idx]   <= 8'd1;
                    for (int j = 0; j < NUM_BUFFERS; j++)
                        if (r_rank[j] > e_rank)
                            r_rank[j] <= r_rank[j] - 1'b1;
                    r_rank[rd_idx] <= RANK_TOP;
                    r_ov    <= 1'b1;
                    r_res   <= mk_res(rd_slot, ST_MISS, IO_READ, r_item.dev, r_item.blk,
                                      1'b0, 1'b1);
                    r_state <= S_IDLE;
                end
                S_FLUSH: begin
                    if (e_val && e_dirty &&
                        (r_item.op == OP_FLUSH_ALL || e_tdev == r_item.dev)) begin
                        r_ov  <= 1'b1;
                        r_res <= mk_res(rd_slot, ST_DONE, IO_WRITE, e_tdev, e_tblk,
                                        1'b1, 1'b0);
                    end
                    r_idx <= r_idx + 1'b1;
                    if (idx_last)
                        r_state <= S_FLUSH_END;
                end
                S_FLUSH_END: begin
                    r_ov    <= 1'b1;
                    r_res   <= mk_res('0, ST_DONE, IO_NONE, '0, '0, 1'b0, 1'b1);
                    r_state <= S_IDLE;
                end
                S_INV: begin
                    if (r_item.op == OP_INV_ALL ||
                        (e_tdev == r_item.dev && e_cnt == 8'd0)) begin
                        if (r_item.op == OP_INV_ALL)
                            r_tdev[rd_idx] <= '0;
                        r_tblk[rd_idx]  <= '0;
                        r_map[rd_idx]   <= 1'b0;
                        r_val[rd_idx]   <= 1'b0;
                        r_dirty[rd_idx] <= 1'b0;
                        for (int j = 0; j < NUM_BUFFERS; j++)
                            if (r_rank[j] < e_rank)
                                r_rank[j] <= r_rank[j] + 1'b1;
                        r_rank[rd_idx] <= '0;
                    end
                    r_idx <= r_idx + 1'b1;
                    if (idx_last) begin
                        r_ov    <= 1'b1;
                        r_res   <= mk_res('0, ST_DONE, IO_NONE, '0, '0, 1'b0, 1'b1);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hw/rtl/block_buffer_cache_lru.sv =====
// ----------------------------------------------------------------------------
// block_buffer_cache_lru
// Fully associative LRU tag and replacement engine for a block buffer cache.
// ----------------------------------------------------------------------------
// Requests are taken while busy is low and queue two deep ahead of the engine.
// Results appear for one cycle with o_valid and cannot be held off; a get miss
// and a flush can give several results, o_last marks the final one. Once an
// item reaches the engine, a get hit or a slot request ends in lookup, a get
// miss scans every slot then stops at the victim state or goes on to fill,
// a flush walks every slot then its end state and an invalidate every slot,
// all set by the engine's single slot-store read port, one slot per cycle.
module block_buffer_cache_lru (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_req_type,
    input  logic [7:0]  i_dev_id,
    input  logic [31:0] i_block_num,
    input  logic [3:0]  i_slot,
    input  logic        i_io_ok,
    output logic        o_valid,
    output logic [3:0]  o_slot_out,
    output logic [1:0]  o_status,
    output logic [1:0]  o_io_cmd,
    output logic [7:0]  o_cmd_dev,
    output logic [31:0] o_cmd_block,
    output logic        o_entry_ready,
    output logic        o_last
);
    import bbc_pkg::*;

    logic    q_full;
    logic    push;
    t_item   f_item;
    logic    q_valid;
    t_item   q_item;
    logic    pop;
    t_result res;

    bbc_front u_front (
        .start       (start),
        .i_req_type  (i_req_type),
        .i_dev_id    (i_dev_id),
        .i_block_num (i_block_num),
        .i_slot      (i_slot),
        .i_io_ok     (i_io_ok),
        .i_q_full    (q_full),
        .o_busy      (busy),
        .o_push      (push),
        .o_item      (f_item)
    );

    bbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    bbc_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_item    (q_item),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .o_res     (res)
    );

    assign o_slot_out    = res.slot;
    assign o_status      = res.status;
    assign o_io_cmd      = res.io_cmd;
    assign o_cmd_dev     = res.dev;
    assign o_cmd_block   = res.blk;
    assign o_entry_ready = res.ready;
    assign o_last        = res.last;

endmodule

// ===== hw/rtl/bbc_checker.sv =====
// ----------------------------------------------------------------------------
// bbc_checker
// Port-level checks on the results of the block buffer cache.
// ----------------------------------------------------------------------------
`include "block_buffer_cache_lru_defines.svh"

module bbc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [3:0]  i_req_type,
    input logic [7:0]  i_dev_id,
    input logic [31:0] i_block_num,
    input logic [3:0]  i_slot,
    input logic        i_io_ok,
    input logic        o_valid,
    input logic [3:0]  o_slot_out,
    input logic [1:0]  o_status,
    input logic [1:0]  o_io_cmd,
    input logic [7:0]  o_cmd_dev,
    input logic [31:0] o_cmd_block,
    input logic        o_entry_ready,
    input logic        o_last
);
    import bbc_pkg::*;

    // a result without a command carries no tag
    `BBC_ASSERT_NOW(a_no_cmd_no_tag, o_valid && o_io_cmd == IO_NONE, o_cmd_dev == '0 && o_cmd_block == '0)
    // running out of buffers ends the item at slot zero
    `BBC_ASSERT_NOW(a_no_free_last, o_valid && o_status == ST_NO_FREE, o_last && o_slot_out == '0 && o_io_cmd == IO_NONE)
    // a read fill is always the closing result of a miss
    `BBC_ASSERT_NOW(a_fill_last, o_valid && o_io_cmd == IO_READ, o_status == ST_MISS && o_last && !o_entry_ready)
    // a miss write-back is always followed by its read fill
    `BBC_ASSERT_NEXT(a_wb_then_fill, o_valid && o_status == ST_MISS && o_io_cmd == IO_WRITE, o_valid && o_io_cmd == IO_READ)

endmodule

bind block_buffer_cache_lru bbc_checker u_bbc_checker (.*);

// ===== tb/tb_block_buffer_cache_lru.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_block_buffer_cache_lru
// Self-checking bench for the LRU block buffer cache tag engine.
// ----------------------------------------------------------------------------
// A short table of directed requests, a pin-every-slot run and a count
// saturation run are followed by random request traffic built mostly from
// get / fill / dirty / put / writeback sequences, with flushes, invalidates
// and unknown codes mixed in. Every accepted item runs through a local cache
// model; each result strobe is compared with the oldest expected result.
// ----------------------------------------------------------------------------
module tb_block_buffer_cache_lru;
    import bbc_pkg::*;

    localparam int          SLOTS      = NUM_BUFFERS;
    localparam logic [3:0]  REQ_BAD_LO = 4'd9;
    localparam logic [3:0]  REQ_BAD_HI = 4'd15;
    localparam int          STALL_MAX  = 1000;
    localparam int          N_RAND     = 40;

    typedef struct {
        logic [3:0]  req;
        logic [7:0]  dev;
        logic [31:0] blk;
        logic [3:0]  slot;
        logic        ok;
    } t_req_item;

    typedef struct {
        t_req_item it;
        bit        typed;
        t_result   want;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [3:0]  i_req_type = '0;
    logic [7:0]  i_dev_id = '0;
    logic [31:0] i_block_num = '0;
    logic [3:0]  i_slot = '0;
    logic        i_io_ok = 1'b0;
    logic        o_valid;
    logic [3:0]  o_slot_out;
    logic [1:0]  o_status;
    logic [1:0]  o_io_cmd;
    logic [7:0]  o_cmd_dev;
    logic [31:0] o_cmd_block;
    logic        o_entry_ready;
    logic        o_last;

    block_buffer_cache_lru uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_dev_id(i_dev_id), .i_block_num(i_block_num),
        .i_slot(i_slot), .i_io_ok(i_io_ok), .o_valid(o_valid),
        .o_slot_out(o_slot_out), .o_status(o_status), .o_io_cmd(o_io_cmd),
        .o_cmd_dev(o_cmd_dev), .o_cmd_block(o_cmd_block),
        .o_entry_ready(o_entry_ready), .o_last(o_last)
    );

    always #10 i_clk = ~i_clk;

    // model state of the tag store
    logic [7:0]  c_dev   [SLOTS];
    logic [31:0] c_blk   [SLOTS];
    bit          c_map   [SLOTS];
    bit          c_val   [SLOTS];
    bit          c_dirty [SLOTS];
    logic [7:0]  c_cnt   [SLOTS];
    logic [3:0]  c_rank  [SLOTS];

    t_result   pred_q[$];
    t_result   want_q[$];
    t_dir_row  dir_tab[$];
    int        errors   = 0;
    int        n_items  = 0;
    int        n_results = 0;
    bit        idle_on  = 1'b1;

    function automatic t_result res(logic [3:0] s, logic [1:0] st, logic [1:0] io,
                                    logic [7:0] d, logic [31:0] b, bit rdy, bit lst);
        t_result r;
        r.slot = s; r.status = st; r.io_cmd = io; r.dev = d; r.blk = b;
        r.ready = rdy; r.last = lst;
        return r;
    endfunction

    task automatic to_newest(int s);
        for (int j = 0; j < SLOTS; j++)
            if (c_rank[j] > c_rank[s]) c_rank[j]--;
        c_rank[s] = 4'(SLOTS - 1);
    endtask

    task automatic to_oldest(int s);
        for (int j = 0; j < SLOTS; j++)
            if (c_rank[j] < c_rank[s]) c_rank[j]++;
        c_rank[s] = 0;
    endtask

    task automatic evict(int s);
        c_map[s] = 0; c_val[s] = 0; c_dirty[s] = 0; c_blk[s] = '0;
        to_oldest(s);
    endtask

    task automatic cache_reset();
        for (int i = 0; i < SLOTS; i++) begin
            c_dev[i] = '0; c_blk[i] = '0; c_map[i] = 0; c_val[i] = 0;
            c_dirty[i] = 0; c_cnt[i] = '0; c_rank[i] = 4'(i);
        end
    endtask

    // fill pred_q with the results one request causes and update the model
    task automatic cache_predict(t_req_item it);
        int v;
        int s;
        bit hit;
        pred_q.delete();
        s = it.slot;
        case (it.req)
            REQ_GET: begin
                hit = 0;
                for (int i = 0; i < SLOTS && !hit; i++) begin
                    if (c_map[i] && c_dev[i] == it.dev && c_blk[i] == it.blk) begin
                        hit = 1;
                        if (c_cnt[i] != 8'hFF) c_cnt[i]++;
                        to_newest(i);
                        pred_q.push_back(res(4'(i), ST_HIT, IO_NONE, 0, 0, c_val[i], 1));
                    end
                end
                if (!hit) begin
                    v = SLOTS;
                    for (int i = 0; i < SLOTS; i++)
                        if (c_cnt[i] == 0 && (v == SLOTS || c_rank[i] < c_rank[v])) v = i;
                    if (v == SLOTS) begin
                        pred_q.push_back(res(0, ST_NO_FREE, IO_NONE, 0, 0, 0, 1));
                    end else begin
                        if (c_val[v] && c_dirty[v])
                            pred_q.push_back(res(4'(v), ST_MISS, IO_WRITE, c_dev[v],
                                                 c_blk[v], 0, 0));
                        c_dev[v] = it.dev; c_blk[v] = it.blk; c_map[v] = 1;
                        c_val[v] = 0; c_dirty[v] = 0; c_cnt[v] = 1;
                        to_newest(v);
                        pred_q.push_back(res(4'(v), ST_MISS, IO_READ, it.dev, it.blk, 0, 1));
                    end
                end
            end
            REQ_FLUSH_DEV, REQ_FLUSH_ALL: begin
                for (int i = 0; i < SLOTS; i++)
                    if (c_val[i] && c_dirty[i] &&
                        (it.req == REQ_FLUSH_ALL || c_dev[i] == it.dev))
                        pred_q.push_back(res(4'(i), ST_DONE, IO_WRITE, c_dev[i], c_blk[i],
                                             1, 0));
                pred_q.push_back(res(0, ST_DONE, IO_NONE, 0, 0, 0, 1));
            end
            REQ_INV_DEV: begin
                for (int i = 0; i < SLOTS; i++)
                    if (c_dev[i] == it.dev && c_cnt[i] == 0) evict(i);
                pred_q.push_back(res(0, ST_DONE, IO_NONE, 0, 0, 0, 1));
            end
            REQ_INV_ALL: begin
                for (int i = 0; i < SLOTS; i++) begin
                    c_dev[i] = '0;
                    evict(i);
                end
                pred_q.push_back(res(0, ST_DONE, IO_NONE, 0, 0, 0, 1));
            end
            REQ_PUT, REQ_DIRTY, REQ_FILL_DONE, REQ_WB_DONE: begin
                if (it.req == REQ_PUT) begin
                    if (c_cnt[s] != 0) c_cnt[s]--;
                    if (c_cnt[s] == 0 && c_val[s] && c_dirty[s])
                        pred_q.push_back(res(it.slot, ST_DONE, IO_WRITE, c_dev[s], c_blk[s],
                                             1, 1));
                end else if (it.req == REQ_DIRTY) begin
                    c_dirty[s] = 1;
                end else if (it.req == REQ_FILL_DONE) begin
                    if (c_map[s] && !c_val[s]) begin
                        if (it.ok) begin
                            c_val[s] = 1;
                        end else begin
                            c_map[s] = 0; c_dirty[s] = 0; c_cnt[s] = 0;
                            to_oldest(s);
                        end
                    end
                end else begin
                    if (it.ok) c_dirty[s] = 0;
                end
                if (pred_q.size() == 0)
                    pred_q.push_back(res(it.slot, ST_DONE, IO_NONE, 0, 0, c_val[s], 1));
            end
            default: pred_q.push_back(res(0, ST_DONE, IO_NONE, 0, 0, 0, 1));
        endcase
    endtask

    task automatic send(t_req_item it, bit typed, t_result want);
        int gap;
        i_req_type  <= it.req;
        i_dev_id    <= it.dev;
        i_block_num <= it.blk;
        i_slot      <= it.slot;
        i_io_ok     <= it.ok;
        start       <= 1'b1;
        do @(posedge i_clk); while (busy);
        cache_predict(it);
        if (typed) want_q.push_back(want);
        else foreach (pred_q[k]) want_q.push_back(pred_q[k]);
        n_items++;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (want_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    function automatic t_req_item mk(logic [3:0] r, logic [7:0] d, logic [31:0] b,
                                     logic [3:0] s, logic ok);
        t_req_item it;
        it.req = r; it.dev = d; it.blk = b; it.slot = s; it.ok = ok;
        return it;
    endfunction

    task automatic add_row(t_req_item it, bit typed, t_result want);
        t_dir_row row;
        row.it = it; row.typed = typed; row.want = want;
        dir_tab.push_back(row);
    endtask

    // pick a slot that is in use most of the time so sequences go deep
    function automatic logic [3:0] pick_slot(bit want_unfilled);
        int base;
        int j;
        base = $urandom_range(0, SLOTS - 1);
        if ($urandom_range(0, 9) < 8) begin
            for (int k = 0; k < SLOTS; k++) begin
                j = (base + k) % SLOTS;
                if (c_map[j] && (!want_unfilled || !c_val[j])) return 4'(j);
            end
        end
        return 4'(base);
    endfunction

    function automatic t_req_item rand_item();
        t_req_item it;
        int w;
        w = $urandom_range(0, 99);
        it.dev  = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        it.blk  = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 11) : $urandom;
        it.ok   = ($urandom_range(0, 3) != 0);
        it.slot = pick_slot(0);
        if (w < 36)      it.req = REQ_GET;
        else if (w < 56) it.req = REQ_PUT;
        else if (w < 66) it.req = REQ_DIRTY;
        else if (w < 79) begin
            it.req = REQ_FILL_DONE;
            it.slot = pick_slot(1);
        end
        else if (w < 87) it.req = REQ_WB_DONE;
        else if (w < 90) it.req = REQ_FLUSH_DEV;
        else if (w < 93) it.req = REQ_FLUSH_ALL;
        else if (w < 96) it.req = REQ_INV_DEV;
        else if (w < 97) it.req = REQ_INV_ALL;
        else it.req = 4'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
        return it;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result w;
        if (i_rst_n && o_valid) begin
            n_results++;
            if (want_q.size() == 0) begin
                $display("%0t unexpected result: expected none actual slot %0d status %0d",
                         $time, o_slot_out, o_status);
                errors++;
            end else begin
                w = want_q.pop_front();
                check_field("slot_out", w.slot, o_slot_out);
                check_field("status", w.status, o_status);
                check_field("io_cmd", w.io_cmd, o_io_cmd);
                check_field("cmd_dev", w.dev, o_cmd_dev);
                check_field("cmd_block", w.blk, o_cmd_block);
                check_field("entry_ready", w.ready, o_entry_ready);
                check_field("last", w.last, o_last);
            end
        end
    end

    // stop if nothing moves for too long
    int quiet = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet <= 0;
        end else if (quiet >= STALL_MAX) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        t_result   none;
        t_req_item it;
        none = res(0, 0, 0, 0, 0, 0, 0);
        cache_reset();

        add_row(mk(REQ_GET, 8'h00, 32'h0, 4'd0, 1'b0), 1,
                res(0, ST_MISS, IO_READ, 8'h00, 32'h0, 0, 1));
        add_row(mk(REQ_FILL_DONE, 8'h00, 32'h0, 4'd0, 1'b1), 1,
                res(0, ST_DONE, IO_NONE, 0, 0, 1, 1));
        add_row(mk(REQ_GET, 8'h00, 32'h0, 4'd0, 1'b0), 1,
                res(0, ST_HIT, IO_NONE, 0, 0, 1, 1));
        add_row(mk(REQ_DIRTY, 8'h00, 32'h0, 4'd0, 1'b0), 0, none);
        add_row(mk(REQ_PUT, 8'h00, 32'h0, 4'd0, 1'b0), 0, none);
        add_row(mk(REQ_PUT, 8'h00, 32'h0, 4'd0, 1'b0), 0, none);
        add_row(mk(REQ_GET, 8'hFF, 32'hFFFF_FFFF, 4'd15, 1'b1), 0, none);
        add_row(mk(REQ_FILL_DONE, 8'h00, 32'h0, 4'd1, 1'b0), 0, none);
        add_row(mk(REQ_GET, 8'hFF, 32'hFFFF_FFFF, 4'd0, 1'b0), 0, none);
        add_row(mk(REQ_FILL_DONE, 8'h00, 32'h0, 4'd1, 1'b1), 0, none);
        add_row(mk(REQ_FILL_DONE, 8'h00, 32'h0, 4'd1, 1'b0), 0, none);
        add_row(mk(REQ_DIRTY, 8'h00, 32'h0, 4'd1, 1'b0), 0, none);
        add_row(mk(REQ_DIRTY, 8'h00, 32'h0, 4'd0, 1'b0), 0, none);
        add_row(mk(REQ_FLUSH_DEV, 8'hFF, 32'h0, 4'd0, 1'b0), 0, none);
        add_row(mk(REQ_FLUSH_ALL, 8'h00, 32'h0, 4'd0, 1'b0), 0, none);
        add_row(mk(REQ_WB_DONE, 8'h00, 32'h0, 4'd1, 1'b0), 0, none);
        add_row(mk(REQ_WB_DONE, 8'h00, 32'h0, 4'd1, 1'b1), 0, none);
        add_row(mk(REQ_PUT, 8'h00, 32'h0, 4'd15, 1'b0), 1,
                res(15, ST_DONE, IO_NONE, 0, 0, 0, 1));
        add_row(mk(REQ_INV_DEV, 8'hFF, 32'h0, 4'd0, 1'b0), 0, none);
        add_row(mk(REQ_BAD_LO, 8'h00, 32'h0, 4'd0, 1'b0), 1,
                res(0, ST_DONE, IO_NONE, 0, 0, 0, 1));
        add_row(mk(REQ_BAD_HI, 8'hFF, 32'hFFFF_FFFF, 4'd15, 1'b1), 1,
                res(0, ST_DONE, IO_NONE, 0, 0, 0, 1));
        add_row(mk(REQ_PUT, 8'h00, 32'h0, 4'd1, 1'b0), 0, none);
        add_row(mk(REQ_INV_DEV, 8'h00, 32'h0, 4'd0, 1'b0), 0, none);
        add_row(mk(REQ_INV_ALL, 8'h00, 32'h0, 4'd0, 1'b0), 1,
                res(0, ST_DONE, IO_NONE, 0, 0, 0, 1));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[r]) send(dir_tab[r].it, dir_tab[r].typed, dir_tab[r].want);
        drain();

        // pin every slot, then one more get finds no free buffer
        for (int k = 0; k <= SLOTS; k++) begin
            send(mk(REQ_GET, 8'h5A, 32'h1000 + k, 4'd0, 1'b0), 0, none);
            send(mk(REQ_FILL_DONE, 8'h00, 32'h0, pick_slot(1), 1'b1), 0, none);
        end
        for (int k = 0; k < SLOTS; k++)
            send(mk(REQ_PUT, 8'h00, 32'h0, 4'(k), 1'b0), 0, none);

        // hammer one tag until its count saturates
        idle_on = 1'b0;
        for (int k = 0; k < 258; k++)
            send(mk(REQ_GET, 8'hA5, 32'hDEAD_BEEF, 4'd0, 1'b0), 0, none);
        idle_on = 1'b1;

        for (int k = 0; k < N_RAND; k++) begin
            if (k % 20 == 10) idle_on = !idle_on;
            if (k == N_RAND / 2) drain();
            it = rand_item();
            send(it, 0, none);
        end

        drain();
        $display("Ran %0d requests (directed, pin-all, count saturation, random mix)",
                 n_items);
        $display("Checked %0d result strobes, %0d mismatches", n_results, errors);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
